[hw/rtl/xml_stream_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// XML stream tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef XML_STREAM_TOKENIZER_MACROS_SVH
`define XML_STREAM_TOKENIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XST_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/xst_pkg.sv]
// ----------------------------------------------------------------------------
// XML stream tokenizer package
// Scanner modes, event and content codes, scanner state and result types.
// ----------------------------------------------------------------------------
package xst_pkg;

	typedef enum logic [10:0] {
		M_ROOT       = 11'b000_0000_0001,
		M_TEXT       = 11'b000_0000_0010,
		M_NAME       = 11'b000_0000_0100,
		M_STAG       = 11'b000_0000_1000,
		M_ETAG       = 11'b000_0001_0000,
		M_CLOSE      = 11'b000_0010_0000,
		M_ATTR       = 11'b000_0100_0000,
		M_AFTER_NAME = 11'b000_1000_0000,
		M_VAL_BEGIN  = 11'b001_0000_0000,
		M_VAL_SQ     = 11'b010_0000_0000,
		M_VAL_DQ     = 11'b100_0000_0000
	} mode_t;

	typedef enum logic [1:0] {
		TGT_START = 2'd0,
		TGT_END   = 2'd1,
		TGT_ATTR  = 2'd2
	} tgt_t;

	typedef enum logic [2:0] {
		EV_CONTENT   = 3'd0,
		EV_START     = 3'd1,
		EV_END       = 3'd2,
		EV_ATTR_VAL  = 3'd3,
		EV_ATTR_BARE = 3'd4,
		EV_TEXT_END  = 3'd5,
		EV_ERROR     = 3'd6
	} ev_t;

	typedef enum logic [2:0] {
		CL_START_NAME = 3'd0,
		CL_END_NAME   = 3'd1,
		CL_ATTR_NAME  = 3'd2,
		CL_ATTR_VALUE = 3'd3,
		CL_TEXT       = 3'd4
	} cls_t;

	typedef enum logic {
		REQ_BYTE   = 1'b0,
		REQ_FINISH = 1'b1
	} req_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		mode_t mode;
		tgt_t  tgt;
		logic  btw;
		logic  err;
		logic  fin;
	} scan_st_t;

	typedef struct packed {
		ev_t        kind;
		cls_t       cls;
		logic [7:0] data;
		logic       last;
	} res_t;

	localparam scan_st_t SCAN_RESET = '{
		mode: M_ROOT, tgt: TGT_START, btw: 1'b1, err: 1'b0, fin: 1'b0
	};

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) || (b == CH_SPACE);
	endfunction

	function automatic logic is_name_start(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))
			|| (b == 8'h5F);
	endfunction

	function automatic logic is_name_char(input logic [7:0] b);
		return is_name_start(b) || ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h2D)
			|| (b == 8'h2E);
	endfunction

endpackage

[hw/rtl/xst_if.sv]
// ----------------------------------------------------------------------------
// XML stream tokenizer channels
// Valid/ready channels for document bytes in and token events out.
// ----------------------------------------------------------------------------
interface xst_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface xst_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [2:0] content_class;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output event_kind, output content_class,
		output out_byte, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input content_class,
		input out_byte, input last_of_run, output ready);
endinterface

[hw/rtl/xml_stream_tokenizer.sv]
// A taken beat is registered in the input stage, and its results then in the result queue.
// Throughput: one document beat per cycle while each beat yields at most one result and the
// queue has room for two; a two-result beat drains at one result a cycle as events are taken.
// Reset: arst_n clears the scanner to between tags, the error and finish flags, and the queue.
// ----------------------------------------------------------------------------
// XML stream tokenizer
// Scans an XML byte stream and emits tagged content bytes and markup events.
// ----------------------------------------------------------------------------
`include "xml_stream_tokenizer_macros.svh"

module xml_stream_tokenizer #(
	parameter int FifoDepth = 4
) (
	input logic       clk,
	input logic       arst_n,
	xst_in_if.sink    bytes,
	xst_out_if.source events
);
	import xst_pkg::*;

	localparam int CntW = $clog2(FifoDepth + 1);

	logic            valid_s1;
	logic            req_type_s1;
	logic [7:0]      data_byte_s1;
	scan_st_t        st_q;
	scan_st_t        st_nxt;
	res_t            res [2];
	logic [1:0]      res_n;
	logic [1:0]      push_n;
	logic            go;
	logic            room2;
	logic            pop;
	logic            not_empty;
	res_t            head;
	logic [CntW-1:0] count;

	assign go = valid_s1 && room2;
	assign bytes.ready = !valid_s1 || go;
	assign push_n = go ? res_n : 2'd0;
	assign pop = events.valid && events.ready;

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			req_type_s1 <= bytes.req_type;
			data_byte_s1 <= bytes.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= SCAN_RESET;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (go) begin
				st_q <= st_nxt;
			end
		end
	end

	xst_scan u_scan (
		.st       (st_q),
		.req_type (req_type_s1),
		.data_byte(data_byte_s1),
		.st_nxt   (st_nxt),
		.res      (res),
		.res_n    (res_n)
	);

	xst_res_fifo #(
		.Depth(FifoDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_res (res),
		.push_n   (push_n),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.room2    (room2),
		.count    (count)
	);

	assign events.valid = not_empty;
	assign events.event_kind = head.kind;
	assign events.content_class = head.cls;
	assign events.out_byte = head.data;
	assign events.last_of_run = head.last;

	`XST_ASSERT_NEXT(a_err_sticky, st_q.err, st_q.err, "error flag dropped")
	`XST_ASSERT_NEXT(a_fin_sticky, st_q.fin, st_q.fin, "finish flag dropped")
	`XST_ASSERT_SAME(a_no_res_after_stop, go && (st_q.err || st_q.fin), res_n == 2'd0, "result after stop")
	`XST_ASSERT_SAME(a_queue_bound, 1'b1, count <= CntW'(FifoDepth), "result queue overflow")

endmodule

[hw/rtl/xst_scan.sv]
// ----------------------------------------------------------------------------
// XML stream tokenizer scan step
// Next scanner state and up to two results for one document beat.
// ----------------------------------------------------------------------------
module xst_scan (
	input  xst_pkg::scan_st_t st,
	input  logic              req_type,
	input  logic [7:0]        data_byte,
	output xst_pkg::scan_st_t st_nxt,
	output xst_pkg::res_t     res [2],
	output logic [1:0]        res_n
);
	import xst_pkg::*;

	always_comb begin
		scan_st_t s;
		logic [1:0] n;
		logic done;
		logic again;
		logic fail;
		logic emit;
		ev_t ek;
		cls_t ec;
		logic [7:0] ed;
		logic [7:0] b;

		s = st;
		n = 2'd0;
		done = 1'b0;
		b = data_byte;
		res[0] = '{kind: EV_CONTENT, cls: CL_START_NAME, data: 8'd0, last: 1'b0};
		res[1] = '{kind: EV_CONTENT, cls: CL_START_NAME, data: 8'd0, last: 1'b0};

		if (st.err || st.fin) begin
			done = 1'b1;
		end else if (req_t'(req_type) == REQ_FINISH) begin
			done = 1'b1;
			if (!st.btw) begin
				res[0] = '{kind: EV_ERROR, cls: CL_START_NAME, data: 8'd0, last: 1'b0};
				n = 2'd1;
				s.err = 1'b1;
			end else begin
				s.fin = 1'b1;
			end
		end

		for (int p = 0; p < 3; p++) begin
			again = 1'b0;
			fail = 1'b0;
			emit = 1'b0;
			ek = EV_CONTENT;
			ec = CL_START_NAME;
			ed = 8'd0;
			if (!done) begin
				unique case (s.mode)
					M_TEXT: begin
						emit = 1'b1;
						if (b == CH_LT) begin
							ek = EV_TEXT_END;
							s.btw = 1'b0;
							s.tgt = TGT_START;
							s.mode = M_STAG;
						end else begin
							ec = CL_TEXT;
							ed = b;
						end
					end
					M_STAG: begin
						if (b == CH_SLASH) begin
							s.tgt = TGT_END;
							s.mode = M_ETAG;
						end else if (is_name_start(b)) begin
							emit = 1'b1;
							ec = cls_t'({1'b0, s.tgt});
							ed = b;
							s.mode = M_NAME;
						end else begin
							fail = 1'b1;
						end
					end
					M_ETAG: begin
						if (is_name_start(b)) begin
							emit = 1'b1;
							ec = cls_t'({1'b0, s.tgt});
							ed = b;
							s.mode = M_NAME;
						end else begin
							fail = 1'b1;
						end
					end
					M_NAME: begin
						if (is_name_char(b)) begin
							emit = 1'b1;
							ec = cls_t'({1'b0, s.tgt});
							ed = b;
						end else if (s.tgt == TGT_END) begin
							emit = 1'b1;
							ek = EV_END;
							s.mode = M_CLOSE;
							again = 1'b1;
						end else if (s.tgt == TGT_ATTR) begin
							s.mode = M_AFTER_NAME;
							again = 1'b1;
						end else begin
							emit = 1'b1;
							ek = EV_START;
							s.mode = M_ATTR;
							again = 1'b1;
						end
					end
					M_CLOSE: begin
						if (b == CH_GT) begin
							s.btw = 1'b1;
							s.mode = M_ROOT;
						end else begin
							fail = 1'b1;
						end
					end
					M_ATTR: begin
						if (is_ws(b)) begin
							s.mode = M_ATTR;
						end else if (b == CH_SLASH) begin
							emit = 1'b1;
							ek = EV_END;
							s.mode = M_CLOSE;
						end else if (b == CH_GT) begin
							s.btw = 1'b1;
							s.mode = M_ROOT;
						end else if (is_name_start(b)) begin
							emit = 1'b1;
							ec = CL_ATTR_NAME;
							ed = b;
							s.tgt = TGT_ATTR;
							s.mode = M_NAME;
						end else begin
							fail = 1'b1;
						end
					end
					M_AFTER_NAME: begin
						if (is_ws(b)) begin
							s.mode = M_AFTER_NAME;
						end else if (b == CH_EQ) begin
							s.mode = M_VAL_BEGIN;
						end else if (b == CH_SLASH || b == CH_GT || is_name_start(b)) begin
							emit = 1'b1;
							ek = EV_ATTR_BARE;
							s.mode = M_ATTR;
							again = 1'b1;
						end else begin
							fail = 1'b1;
						end
					end
					M_VAL_BEGIN: begin
						if (is_ws(b)) begin
							s.mode = M_VAL_BEGIN;
						end else if (b == CH_DQ) begin
							s.mode = M_VAL_DQ;
						end else if (b == CH_SQ) begin
							s.mode = M_VAL_SQ;
						end else begin
							fail = 1'b1;
						end
					end
					M_VAL_SQ, M_VAL_DQ: begin
						if (b < CH_SPACE) begin
							fail = 1'b1;
						end else if (b == ((s.mode == M_VAL_SQ) ? CH_SQ : CH_DQ)) begin
							emit = 1'b1;
							ek = EV_ATTR_VAL;
							s.mode = M_ATTR;
						end else begin
							emit = 1'b1;
							ec = CL_ATTR_VALUE;
							ed = b;
						end
					end
					default: begin
						if (is_ws(b)) begin
							s.mode = M_ROOT;
						end else if (b == CH_LT) begin
							s.btw = 1'b0;
							s.tgt = TGT_START;
							s.mode = M_STAG;
						end else if (b < CH_SPACE) begin
							fail = 1'b1;
						end else begin
							emit = 1'b1;
							ec = CL_TEXT;
							ed = b;
							s.mode = M_TEXT;
						end
					end
				endcase

				if (fail) begin
					emit = 1'b1;
					ek = EV_ERROR;
					ec = CL_START_NAME;
					ed = b;
					s.err = 1'b1;
				end
				if (emit && n != 2'd2) begin
					res[n[0]] = '{kind: ek, cls: ec, data: ed, last: 1'b0};
					n = n + 2'd1;
				end
				if (fail || !again) begin
					done = 1'b1;
				end
			end
		end

		if (n == 2'd1) begin
			res[0].last = 1'b1;
		end else if (n == 2'd2) begin
			res[1].last = 1'b1;
		end
		st_nxt = s;
		res_n = n;
	end

endmodule

[hw/rtl/xst_res_fifo.sv]
// ----------------------------------------------------------------------------
// XML stream tokenizer result queue
// Small register queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module xst_res_fifo #(
	parameter int Depth = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  xst_pkg::res_t push_res [2],
	input  logic [1:0]    push_n,
	input  logic          pop,
	output xst_pkg::res_t head,
	output logic          not_empty,
	output logic          room2,
	output logic [$clog2(Depth+1)-1:0] count
);
	import xst_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	res_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic [PtrW-1:0] wr_ptr_p1;
	logic [PtrW-1:0] wr_ptr_p2;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_res[0];
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= wr_ptr_p2;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push_n) - CntW'(pop);
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign room2 = (count_q <= CntW'(Depth - 2));
	assign count = count_q;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// XML stream tokenizer testbench
// Feeds a directed document and then random markup through the tokenizer
// under four idling mixes, predicts every token and event, and closes with
// one terminal case: a clean finish, an open tag at finish, random bytes
// until an error, or a disallowed byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import xst_pkg::*;

	typedef struct packed {
		req_t       rq;
		logic [7:0] b;
		int         n_want;
		res_t       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	xst_in_if  doc_bus ();
	xst_out_if ev_bus ();

	xml_stream_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (doc_bus),
		.events (ev_bus)
	);

	always #6 clk = ~clk;

	mode_t st_mode = M_ROOT;
	tgt_t  st_tgt  = TGT_START;
	logic  st_btw  = 1'b1;
	logic  st_err  = 1'b0;
	logic  st_fin  = 1'b0;

	res_t pending_tokens [$];
	int   mismatches = 0;
	int   beats_fed  = 0;
	int   send_idle  = 0;
	int   stall_pct  = 0;

	function automatic res_t make_tok(input ev_t k, input cls_t c, input logic [7:0] d,
		input logic last);
		res_t r;
		r.kind = k;
		r.cls  = c;
		r.data = d;
		r.last = last;
		return r;
	endfunction

	function automatic row_t row(input req_t rq, input logic [7:0] b, input int n_want,
		input ev_t k, input cls_t c, input logic [7:0] d);
		row_t r;
		r.rq     = rq;
		r.b      = b;
		r.n_want = n_want;
		r.want   = make_tok(k, c, d, 1'b1);
		return r;
	endfunction

	function automatic bit ws_byte(input logic [7:0] b);
		case (b)
			8'h09, 8'h0A, 8'h0D, 8'h20: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit lead_byte(input logic [7:0] b);
		return (b == 8'h5F) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic bit body_byte(input logic [7:0] b);
		return lead_byte(b) || (b >= "0" && b <= "9") || b == "-" || b == ".";
	endfunction

	function automatic cls_t name_cls();
		case (st_tgt)
			TGT_END: return CL_END_NAME;
			TGT_ATTR: return CL_ATTR_NAME;
			default: return CL_START_NAME;
		endcase
	endfunction

	function automatic void add_tok(input ev_t k, input cls_t c, input logic [7:0] d,
		inout int n);
		pending_tokens.push_back(make_tok(k, c, d, 1'b0));
		n++;
	endfunction

	function automatic void tokenize_beat(input req_t rq, input logic [7:0] b,
		output int n, output res_t first);
		res_t r;
		bit again;
		bit fail;
		int pass;
		n = 0;
		first = '0;
		if (st_err || st_fin)
			return;
		if (rq == REQ_FINISH) begin
			if (!st_btw) begin
				add_tok(EV_ERROR, CL_START_NAME, 8'h00, n);
				st_err = 1'b1;
			end else begin
				st_fin = 1'b1;
			end
		end else begin
			for (pass = 0; pass < 3; pass++) begin
				again = 1'b0;
				fail = 1'b0;
				case (st_mode)
					M_TEXT: begin
						if (b == CH_LT) begin
							add_tok(EV_TEXT_END, CL_START_NAME, 8'h00, n);
							st_btw = 1'b0;
							st_tgt = TGT_START;
							st_mode = M_STAG;
						end else begin
							add_tok(EV_CONTENT, CL_TEXT, b, n);
						end
					end
					M_STAG: begin
						if (b == CH_SLASH) begin
							st_tgt = TGT_END;
							st_mode = M_ETAG;
						end else if (lead_byte(b)) begin
							add_tok(EV_CONTENT, name_cls(), b, n);
							st_mode = M_NAME;
						end else begin
							fail = 1'b1;
						end
					end
					M_ETAG: begin
						if (lead_byte(b)) begin
							add_tok(EV_CONTENT, name_cls(), b, n);
							st_mode = M_NAME;
						end else begin
							fail = 1'b1;
						end
					end
					M_NAME: begin
						if (body_byte(b)) begin
							add_tok(EV_CONTENT, name_cls(), b, n);
						end else if (st_tgt == TGT_END) begin
							add_tok(EV_END, CL_START_NAME, 8'h00, n);
							st_mode = M_CLOSE;
							again = 1'b1;
						end else if (st_tgt == TGT_ATTR) begin
							st_mode = M_AFTER_NAME;
							again = 1'b1;
						end else begin
							add_tok(EV_START, CL_START_NAME, 8'h00, n);
							st_mode = M_ATTR;
							again = 1'b1;
						end
					end
					M_CLOSE: begin
						if (b == CH_GT) begin
							st_btw = 1'b1;
							st_mode = M_ROOT;
						end else begin
							fail = 1'b1;
						end
					end
					M_ATTR: begin
						if (ws_byte(b)) begin
						end else if (b == CH_SLASH) begin
							add_tok(EV_END, CL_START_NAME, 8'h00, n);
							st_mode = M_CLOSE;
						end else if (b == CH_GT) begin
							st_btw = 1'b1;
							st_mode = M_ROOT;
						end else if (lead_byte(b)) begin
							add_tok(EV_CONTENT, CL_ATTR_NAME, b, n);
							st_tgt = TGT_ATTR;
							st_mode = M_NAME;
						end else begin
							fail = 1'b1;
						end
					end
					M_AFTER_NAME: begin
						if (ws_byte(b)) begin
						end else if (b == CH_EQ) begin
							st_mode = M_VAL_BEGIN;
						end else if (b == CH_SLASH || b == CH_GT || lead_byte(b)) begin
							add_tok(EV_ATTR_BARE, CL_START_NAME, 8'h00, n);
							st_mode = M_ATTR;
							again = 1'b1;
						end else begin
							fail = 1'b1;
						end
					end
					M_VAL_BEGIN: begin
						if (ws_byte(b)) begin
						end else if (b == CH_DQ) begin
							st_mode = M_VAL_DQ;
						end else if (b == CH_SQ) begin
							st_mode = M_VAL_SQ;
						end else begin
							fail = 1'b1;
						end
					end
					M_VAL_SQ, M_VAL_DQ: begin
						if (b < 8'h20) begin
							fail = 1'b1;
						end else if (b == ((st_mode == M_VAL_SQ) ? CH_SQ : CH_DQ)) begin
							add_tok(EV_ATTR_VAL, CL_START_NAME, 8'h00, n);
							st_mode = M_ATTR;
						end else begin
							add_tok(EV_CONTENT, CL_ATTR_VALUE, b, n);
						end
					end
					default: begin
						if (ws_byte(b)) begin
						end else if (b == CH_LT) begin
							st_btw = 1'b0;
							st_tgt = TGT_START;
							st_mode = M_STAG;
						end else if (b < 8'h20) begin
							fail = 1'b1;
						end else begin
							add_tok(EV_CONTENT, CL_TEXT, b, n);
							st_mode = M_TEXT;
						end
					end
				endcase
				if (fail) begin
					add_tok(EV_ERROR, CL_START_NAME, b, n);
					st_err = 1'b1;
					break;
				end
				if (!again)
					break;
			end
		end
		if (n > 0) begin
			r = pending_tokens.pop_back();
			r.last = 1'b1;
			pending_tokens.push_back(r);
			first = pending_tokens[pending_tokens.size() - n];
		end
	endfunction

	function automatic void compare_tok(input string where, input res_t want, input res_t got);
		if (got.kind !== want.kind || got.cls !== want.cls || got.data !== want.data
			|| got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"%s mismatch: expected kind %0d class %0d byte %02h last %0b,",
					" got kind %0d class %0d byte %02h last %0b"},
					where, want.kind, want.cls, want.data, want.last,
					got.kind, got.cls, got.data, got.last);
		end
	endfunction

	function automatic void check_typed(input int n_got, input res_t first, input int n_want,
		input res_t want);
		if (n_want < 0)
			return;
		if (n_got != n_want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Table mismatch: expected %0d results for the beat, predicted %0d",
					n_want, n_got);
		end else if (n_want > 0) begin
			compare_tok("Table", want, first);
		end
	endfunction

	task automatic feed(input req_t rq, input logic [7:0] b, output int n, output res_t first);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			doc_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		doc_bus.valid <= 1'b1;
		doc_bus.req_type <= rq;
		doc_bus.data_byte <= b;
		do @(posedge clk); while (doc_bus.ready !== 1'b1);
		beats_fed++;
		tokenize_beat(rq, b, n, first);
	endtask

	task automatic put(input logic [7:0] b);
		int n;
		res_t first;
		feed(REQ_BYTE, b, n, first);
	endtask

	task automatic drain();
		doc_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_lead();
		int r;
		r = $urandom_range(52);
		if (r < 26)
			return 8'h41 + 8'(r);
		if (r < 52)
			return 8'h61 + 8'(r - 26);
		return 8'h5F;
	endfunction

	function automatic logic [7:0] pick_body();
		case ($urandom_range(4))
			0: return 8'h30 + 8'($urandom_range(9));
			1: return ($urandom_range(1) == 0) ? 8'h2D : 8'h2E;
			default: return pick_lead();
		endcase
	endfunction

	function automatic logic [7:0] pick_ws();
		case ($urandom_range(3))
			0: return 8'h09;
			1: return 8'h0A;
			2: return 8'h0D;
			default: return CH_SPACE;
		endcase
	endfunction

	task automatic send_ws(input int max_len);
		repeat ($urandom_range(max_len))
			put(pick_ws());
	endtask

	task automatic send_name();
		put(pick_lead());
		repeat ($urandom_range(5))
			put(pick_body());
	endtask

	task automatic send_text();
		logic [7:0] b;
		do b = 8'($urandom_range(255, 33)); while (b == CH_LT);
		put(b);
		repeat ($urandom_range(7)) begin
			do b = 8'($urandom_range(255)); while (b == CH_LT);
			put(b);
		end
	endtask

	task automatic send_value();
		logic [7:0] q;
		logic [7:0] b;
		q = ($urandom_range(1) == 0) ? CH_SQ : CH_DQ;
		put(q);
		repeat ($urandom_range(5)) begin
			do b = 8'($urandom_range(255, 32)); while (b == q);
			put(b);
		end
		put(q);
	endtask

	task automatic send_start_tag();
		bit need_gap;
		put(CH_LT);
		send_name();
		need_gap = 1'b1;
		repeat ($urandom_range(3)) begin
			if (need_gap || $urandom_range(1) == 0) begin
				repeat ($urandom_range(2, 1))
					put(pick_ws());
			end
			send_name();
			if ($urandom_range(3) != 0) begin
				send_ws(1);
				put(CH_EQ);
				send_ws(1);
				send_value();
				need_gap = 1'b0;
			end else begin
				need_gap = 1'b1;
			end
		end
		send_ws(1);
		if ($urandom_range(2) == 0)
			put(CH_SLASH);
		put(CH_GT);
	endtask

	task automatic send_fragment();
		send_ws(2);
		if ($urandom_range(3) == 0)
			send_text();
		if ($urandom_range(4) < 3) begin
			send_start_tag();
		end else begin
			put(CH_LT);
			put(CH_SLASH);
			send_name();
			put(CH_GT);
		end
	endtask

	always @(posedge clk) begin : watch_events
		res_t seen;
		if (arst_n === 1'b1 && ev_bus.valid === 1'b1 && ev_bus.ready === 1'b1) begin
			seen.kind = ev_t'(ev_bus.event_kind);
			seen.cls  = cls_t'(ev_bus.content_class);
			seen.data = ev_bus.out_byte;
			seen.last = ev_bus.last_of_run;
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: kind %0d class %0d byte %02h last %0b",
						seen.kind, seen.cls, seen.data, seen.last);
			end else begin
				compare_tok("Result", pending_tokens.pop_front(), seen);
			end
		end
	end

	initial begin
		ev_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			ev_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		row_t script [25];
		int i;
		int n;
		int phase;
		int goal;
		int guard;
		res_t first;
		res_t want;
		logic [7:0] b;

		arst_n <= 1'b0;
		doc_bus.valid <= 1'b0;
		doc_bus.req_type <= REQ_BYTE;
		doc_bus.data_byte <= 8'h00;

		script[0]  = row(REQ_BYTE, CH_SPACE, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[1]  = row(REQ_BYTE, CH_LT, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[2]  = row(REQ_BYTE, "A", 1, EV_CONTENT, CL_START_NAME, "A");
		script[3]  = row(REQ_BYTE, "z", -1, EV_CONTENT, CL_START_NAME, 8'h00);
		script[4]  = row(REQ_BYTE, "9", -1, EV_CONTENT, CL_START_NAME, 8'h00);
		script[5]  = row(REQ_BYTE, CH_SPACE, 1, EV_START, CL_START_NAME, 8'h00);
		script[6]  = row(REQ_BYTE, "b", -1, EV_CONTENT, CL_START_NAME, 8'h00);
		script[7]  = row(REQ_BYTE, CH_SPACE, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[8]  = row(REQ_BYTE, CH_EQ, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[9]  = row(REQ_BYTE, 8'h09, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[10] = row(REQ_BYTE, CH_DQ, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[11] = row(REQ_BYTE, 8'hFF, 1, EV_CONTENT, CL_ATTR_VALUE, 8'hFF);
		script[12] = row(REQ_BYTE, CH_DQ, 1, EV_ATTR_VAL, CL_START_NAME, 8'h00);
		script[13] = row(REQ_BYTE, "c", -1, EV_CONTENT, CL_START_NAME, 8'h00);
		script[14] = row(REQ_BYTE, CH_GT, 1, EV_ATTR_BARE, CL_START_NAME, 8'h00);
		script[15] = row(REQ_BYTE, 8'hFF, 1, EV_CONTENT, CL_TEXT, 8'hFF);
		script[16] = row(REQ_BYTE, 8'h00, 1, EV_CONTENT, CL_TEXT, 8'h00);
		script[17] = row(REQ_BYTE, CH_LT, 1, EV_TEXT_END, CL_START_NAME, 8'h00);
		script[18] = row(REQ_BYTE, CH_SLASH, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[19] = row(REQ_BYTE, "A", -1, EV_CONTENT, CL_START_NAME, 8'h00);
		script[20] = row(REQ_BYTE, CH_GT, 1, EV_END, CL_START_NAME, 8'h00);
		script[21] = row(REQ_BYTE, CH_LT, 0, EV_CONTENT, CL_START_NAME, 8'h00);
		script[22] = row(REQ_BYTE, "e", -1, EV_CONTENT, CL_START_NAME, 8'h00);
		script[23] = row(REQ_BYTE, CH_SLASH, -1, EV_CONTENT, CL_START_NAME, 8'h00);
		script[24] = row(REQ_BYTE, CH_GT, 0, EV_CONTENT, CL_START_NAME, 8'h00);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 25; i++) begin
			feed(script[i].rq, script[i].b, n, first);
			check_typed(n, first, script[i].n_want, script[i].want);
		end

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle = 85;
					stall_pct = 0;
				end
				2: begin
					send_idle = 0;
					stall_pct = 85;
				end
				default: begin
					send_idle = 19;
					stall_pct = 19;
				end
			endcase
			goal = beats_fed + 225;
			while (beats_fed < goal)
				send_fragment();
			drain();
		end

		// The scan is back between tags here; every closing case below is terminal.
		case ($urandom_range(3))
			0: begin
				if ($urandom_range(1) == 0)
					send_text();
				feed(REQ_FINISH, 8'($urandom_range(255)), n, first);
				check_typed(n, first, 0, want);
			end
			1: begin
				put(CH_LT);
				send_name();
				feed(REQ_FINISH, 8'($urandom_range(255)), n, first);
				want = make_tok(EV_ERROR, CL_START_NAME, 8'h00, 1'b1);
				check_typed(n, first, 1, want);
			end
			2: begin
				guard = 0;
				while (!st_err && guard < 64) begin
					put(8'($urandom_range(255)));
					guard++;
				end
				if (!st_err)
					feed(REQ_FINISH, 8'h00, n, first);
			end
			default: begin
				do b = 8'($urandom_range(31)); while (ws_byte(b));
				feed(REQ_BYTE, b, n, first);
				want = make_tok(EV_ERROR, CL_START_NAME, b, 1'b1);
				check_typed(n, first, 1, want);
			end
		endcase

		repeat (6) begin
			feed(req_t'($urandom_range(1)), 8'($urandom_range(255)), n, first);
			check_typed(n, first, 0, want);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/xst_pkg.sv
hw/rtl/xst_if.sv
hw/rtl/xst_scan.sv
hw/rtl/xst_res_fifo.sv
hw/rtl/xml_stream_tokenizer.sv
tb/tb.sv
